// File: rtl/rcfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcfs_pkg
// Codes and types shared by the CSMA frame sequencer front end, queue and
// back end.
// ----------------------------------------------------------------------------
package rcfs_pkg;

  // event opcodes
  localparam logic [2:0] OP_TX_REQ   = 3'd0;
  localparam logic [2:0] OP_BACKOFF  = 3'd1;
  localparam logic [2:0] OP_ED_DONE  = 3'd2;
  localparam logic [2:0] OP_TX_END   = 3'd3;
  localparam logic [2:0] OP_RX_START = 3'd4;
  localparam logic [2:0] OP_RX_END   = 3'd5;
  localparam logic [2:0] OP_TIMEOUT  = 3'd6;

  // link states
  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_CSMA    = 3'd1;
  localparam logic [2:0] ST_CSMA_RX = 3'd2;
  localparam logic [2:0] ST_TX      = 3'd3;
  localparam logic [2:0] ST_RX      = 3'd4;

  // report codes
  localparam logic [2:0] REP_NONE      = 3'd0;
  localparam logic [2:0] REP_ACCEPTED  = 3'd1;
  localparam logic [2:0] REP_BUSY      = 3'd2;
  localparam logic [2:0] REP_CCA_FAIL  = 3'd3;
  localparam logic [2:0] REP_TX_OK     = 3'd4;
  localparam logic [2:0] REP_ACK       = 3'd5;
  localparam logic [2:0] REP_ACK_PEND  = 3'd6;
  localparam logic [2:0] REP_DELIVERED = 3'd7;

  // backup timer actions
  localparam logic [1:0] TMR_LEAVE = 2'd0;
  localparam logic [1:0] TMR_START = 2'd1;
  localparam logic [1:0] TMR_STOP  = 2'd2;

  // radio actions
  localparam logic [1:0] RAD_NONE = 2'd0;
  localparam logic [1:0] RAD_ED   = 2'd1;
  localparam logic [1:0] RAD_TX   = 2'd2;
  localparam logic [1:0] RAD_RX   = 2'd3;

  localparam logic [7:0] ENERGY_THR_RESET = 8'hb0;

  // classified event handed from front end to back end
  typedef struct packed {
    logic [2:0] op;
    logic       ack_req;
    logic       is_ack;
    logic       ack_pend;
    logic       frame_ok;
    logic [7:0] seq;
    logic [7:0] tag;
    logic [7:0] energy;
    logic [6:0] dlen;
  } rcfs_cmd_t;

  // one result item
  typedef struct packed {
    logic [2:0] report;
    logic [7:0] report_tag;
    logic [6:0] dlen;
    logic [7:0] dstr;
    logic [1:0] timer;
    logic [1:0] radio;
    logic [2:0] link;
  } rcfs_res_t;

endpackage

// File: rtl/rcfs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcfs_front
// Event classifier: frame version, ack request, ack frame and length checks.
// ----------------------------------------------------------------------------
module rcfs_front
  import rcfs_pkg::*;
#(
  parameter int MAX_FRAME = 127
) (
  input  logic [2:0]  opcode_i,
  input  logic [7:0]  fcl_i,
  input  logic [7:0]  fch_i,
  input  logic [7:0]  seq_i,
  input  logic [10:0] flen_i,
  input  logic [7:0]  tag_i,
  input  logic [7:0]  energy_i,
  input  logic        fcs_ok_i,
  output rcfs_cmd_t   cmd_o
);

  localparam logic [10:0] MaxLen = 11'(MAX_FRAME);

  logic [1:0]  version;
  logic [10:0] len_m2;

  assign version = fch_i[5:4];
  assign len_m2  = flen_i - 11'd2;

  always_comb begin
    cmd_o          = '0;
    cmd_o.op       = opcode_i;
    cmd_o.ack_req  = (version != 2'd2) && fcl_i[5];
    cmd_o.is_ack   = (fcl_i[2:0] == 3'd2) && (version < 2'd2);
    cmd_o.ack_pend = fcl_i[4];
    cmd_o.frame_ok = fcs_ok_i && (flen_i <= MaxLen);
    cmd_o.seq      = seq_i;
    cmd_o.tag      = tag_i;
    cmd_o.energy   = energy_i;
    if (flen_i < 11'd2) begin
      cmd_o.dlen = 7'd0;
    end else if (len_m2 > 11'd127) begin
      cmd_o.dlen = 7'd127;
    end else begin
      cmd_o.dlen = len_m2[6:0];
    end
  end

endmodule

// File: rtl/rcfs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcfs_queue
// Short command queue between the classifier and the sequencer back end.
// ----------------------------------------------------------------------------
module rcfs_queue
  import rcfs_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  rcfs_cmd_t push_data_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      empty_o,
  output rcfs_cmd_t pop_data_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  rcfs_cmd_t         mem_q [DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;

  assign full_o     = (count_q == CntW'(DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("queue push while full");
  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue pop while empty");
  a_count_up : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count did not advance");
`endif

endmodule

// File: rtl/rcfs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcfs_back
// Link state sequencer: carries out queued events and holds the result
// register towards the output channel.
// ----------------------------------------------------------------------------
module rcfs_back
  import rcfs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic      cmd_valid_i,
  input  rcfs_cmd_t cmd_i,
  output logic      cmd_pop_o,
  output logic      res_valid_o,
  input  logic      res_ready_i,
  output rcfs_res_t res_o
);

  logic [7:0] thr_q;
  logic [2:0] state_q, state_d;
  logic       ack_aw_q, ack_aw_d;
  logic [7:0] ack_seq_q, ack_seq_d;
  logic [7:0] held_q, held_d;
  logic       valid_q;
  rcfs_res_t  res_q, res_d;

  assign cmd_pop_o   = cmd_valid_i && (!valid_q || res_ready_i);
  assign res_valid_o = valid_q;
  assign res_o       = res_q;

  always_comb begin
    state_d   = state_q;
    ack_aw_d  = ack_aw_q;
    ack_seq_d = ack_seq_q;
    held_d    = held_q;
    res_d     = '0;
    unique case (cmd_i.op)
      OP_TX_REQ: begin
        if (state_q != ST_IDLE && state_q != ST_RX) begin
          res_d.report     = REP_BUSY;
          res_d.report_tag = cmd_i.tag;
        end else begin
          state_d = (state_q == ST_RX) ? ST_CSMA_RX : ST_CSMA;
          if (cmd_i.ack_req) begin
            ack_seq_d = cmd_i.seq;
            ack_aw_d  = 1'b1;
          end
          held_d           = cmd_i.tag;
          res_d.report     = REP_ACCEPTED;
          res_d.report_tag = cmd_i.tag;
        end
      end
      OP_BACKOFF: begin
        if (state_q == ST_CSMA || state_q == ST_CSMA_RX) begin
          res_d.radio = RAD_ED;
          res_d.timer = TMR_START;
        end
      end
      OP_ED_DONE: begin
        if (state_q == ST_CSMA_RX) begin
          state_d          = ST_RX;
          res_d.report     = REP_CCA_FAIL;
          res_d.report_tag = held_q;
        end else if (state_q == ST_CSMA) begin
          if ($signed(cmd_i.energy) > $signed(thr_q)) begin
            state_d          = ST_IDLE;
            res_d.timer      = TMR_STOP;
            res_d.report     = REP_CCA_FAIL;
            res_d.report_tag = held_q;
          end else begin
            state_d     = ST_TX;
            res_d.timer = TMR_START;
            res_d.radio = RAD_TX;
          end
        end
      end
      OP_TX_END: begin
        if (state_q == ST_TX) begin
          state_d          = ST_IDLE;
          res_d.timer      = TMR_STOP;
          res_d.radio      = RAD_RX;
          res_d.report     = REP_TX_OK;
          res_d.report_tag = held_q;
        end
      end
      OP_RX_START: begin
        if (state_q == ST_IDLE || state_q == ST_CSMA) begin
          state_d     = (state_q == ST_CSMA) ? ST_CSMA_RX : ST_RX;
          res_d.timer = TMR_START;
        end
      end
      OP_RX_END: begin
        if (state_q == ST_RX || state_q == ST_CSMA_RX) begin
          res_d.timer = (state_q == ST_CSMA_RX) ? TMR_START : TMR_STOP;
          state_d     = (state_q == ST_CSMA_RX) ? ST_CSMA : ST_IDLE;
          res_d.radio = RAD_RX;
          if (cmd_i.frame_ok) begin
            if (cmd_i.is_ack) begin
              if (ack_aw_q && ack_seq_q == cmd_i.seq) begin
                res_d.report     = cmd_i.ack_pend ? REP_ACK_PEND : REP_ACK;
                res_d.report_tag = held_q;
                ack_aw_d         = 1'b0;
              end
            end else begin
              res_d.report = REP_DELIVERED;
              res_d.dlen   = cmd_i.dlen;
              res_d.dstr   = cmd_i.energy;
            end
          end
        end
      end
      OP_TIMEOUT: begin
        if (state_q == ST_TX) begin
          res_d.report     = REP_TX_OK;
          res_d.report_tag = held_q;
        end else if (state_q == ST_CSMA || state_q == ST_CSMA_RX) begin
          res_d.report     = REP_CCA_FAIL;
          res_d.report_tag = held_q;
        end
        state_d     = ST_IDLE;
        res_d.radio = RAD_RX;
      end
      default: begin
      end
    endcase
    res_d.link = state_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q     <= ENERGY_THR_RESET;
      state_q   <= ST_IDLE;
      ack_aw_q  <= 1'b0;
      ack_seq_q <= '0;
      held_q    <= '0;
      valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (cmd_pop_o) begin
        state_q   <= state_d;
        ack_aw_q  <= ack_aw_d;
        ack_seq_q <= ack_seq_d;
        held_q    <= held_d;
        valid_q   <= 1'b1;
      end else if (res_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      res_q <= res_d;
    end
  end

`ifndef SYNTHESIS
  a_pop_loads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |=> valid_q)
    else $error("result not loaded after event");
  a_no_pop_stalled : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !res_ready_i) |-> !cmd_pop_o)
    else $error("event taken over a stalled result");
  a_link_matches : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |=> (res_q.link == state_q))
    else $error("reported link state differs from state register");
`endif

endmodule

// File: rtl/radio_csma_frame_sequencer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radio_csma_frame_sequencer_top
// CSMA-CA transmit/receive link sequencer for an 802.15.4 radio.
//
//   channel   dir  payload
//   s_axis    in   tuser: opcode; tdata: frame bytes, length, tag, energy, fcs
//   m_axis    out  tuser: report; tdata: tag, length, strength, actions, link
//   cfg       in   energy threshold write, no read-back
//
// One event per cycle sustained while m_axis is ready; each event passes a queue
// slot, then the result register, on its way from s_axis transfer to m_axis valid.
// A two-entry queue parts the classifier from the state sequencer, so input
// keeps flowing for two events while m_axis stalls.
// Reset clears link state, ack tracking, held tag and threshold (-80).
// ----------------------------------------------------------------------------
module radio_csma_frame_sequencer_top
  import rcfs_pkg::*;
#(
  parameter int MAX_FRAME = 127
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // fcl[7:0] fch[15:8] seq[23:16] flen[34:24] tag[42:35] energy[50:43]
  // fcs_ok[51] zero[55:52]
  input  logic [55:0] s_axis_tdata,
  // opcode[2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // report_tag[7:0] dlen[14:8] dstr[22:15] timer[24:23] radio[26:25]
  // link_state[29:27] zero[31:30]
  output logic [31:0] m_axis_tdata,
  // report[2:0]
  output logic [2:0]  m_axis_tuser
);

  rcfs_cmd_t cmd_in, cmd_out;
  rcfs_res_t res;
  logic      q_full, q_empty, q_pop, push;

  assign s_axis_tready = !q_full;
  assign push          = s_axis_tvalid && !q_full;

  rcfs_front #(
    .MAX_FRAME (MAX_FRAME)
  ) u_front (
    .opcode_i (s_axis_tuser),
    .fcl_i    (s_axis_tdata[7:0]),
    .fch_i    (s_axis_tdata[15:8]),
    .seq_i    (s_axis_tdata[23:16]),
    .flen_i   (s_axis_tdata[34:24]),
    .tag_i    (s_axis_tdata[42:35]),
    .energy_i (s_axis_tdata[50:43]),
    .fcs_ok_i (s_axis_tdata[51]),
    .cmd_o    (cmd_in)
  );

  rcfs_queue #(
    .DEPTH (2)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (cmd_in),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .pop_data_o  (cmd_out)
  );

  rcfs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_valid_i (!q_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (q_pop),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tuser = res.report;
  assign m_axis_tdata = {2'b00, res.link, res.radio, res.timer, res.dstr, res.dlen,
                         res.report_tag};

endmodule
